/* src/sorted_cross_index_table_core_macros.svh */
// Assertion macros shared by the lookup table core.
// Depends on nothing; included by files that assert.
`ifndef SORTED_CROSS_INDEX_TABLE_CORE_MACROS_SVH
`define SORTED_CROSS_INDEX_TABLE_CORE_MACROS_SVH
// implication checked every clock outside reset
`define SXT_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// implication checked on the clock after the antecedent
`define SXT_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

/* src/sxt_pkg.sv */
// Shared types and constants for the sorted cross index table.
// No dependencies.
package sxt_pkg;
   localparam int NumCatalogs = 4;
   localparam int TableDepth  = 1024;
   localparam int CatW  = (NumCatalogs > 1) ? $clog2(NumCatalogs) : 1;
   localparam int PosW  = $clog2(TableDepth);
   localparam int CntW  = PosW + 1;
   localparam int AddrW = CatW + PosW;
   localparam logic [31:0] MissNumber = 32'hFFFF_FFFF;

   typedef enum logic [1:0] {
      MODE_CLEAR = 2'd0, MODE_INSERT = 2'd1, MODE_LOOKUP = 2'd2, MODE_REVERSE = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      ST_OK = 2'd0, ST_BAD_CATALOG = 2'd1, ST_FULL = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE, S_SEARCH, S_SHIFT, S_WRITE, S_SCAN, S_CHECK, S_DONE
   } state_type;

   typedef struct packed {
      logic [1:0]  mode;
      logic [3:0]  catalog;
      logic [31:0] entry_key;
      logic [31:0] entry_value;
   } req_type;

   typedef struct packed {
      logic        found;
      logic [31:0] result_number;
      logic [1:0]  status;
   } rsp_type;

   typedef struct packed {
      logic             we;
      logic [AddrW-1:0] waddr;
      logic [31:0]      wkey;
      logic [31:0]      wval;
      logic [AddrW-1:0] raddr;
   } mem_ctl_type;
endpackage

/* src/sxt_if.sv */
// Valid/ready channel interface for request and response transfers.
// Depends on sxt_pkg.
interface sxt_req_if import sxt_pkg::*; ();
   logic    valid;
   logic    ready;
   req_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface sxt_rsp_if import sxt_pkg::*; ();
   logic    valid;
   logic    ready;
   rsp_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

/* src/sorted_cross_index_table_core.sv */
// Sorted cross index table core. One item at a time: clear, range error or full
// table; lookup by binary search, one store read per search step; insert a search
// plus a read and a write per entry moved up; reverse lookup a scan with one read
// per entry scanned. The single read/write port of the store sets this order.
// Stores are undefined until written; only entries below a table's count are
// used. A result waits in an output register for transfer.
module sorted_cross_index_table_core import sxt_pkg::*; (
   input logic     clock,
   input logic     reset,
   sxt_req_if.sink   req_chan,
   sxt_rsp_if.source rsp_chan
);
   mem_ctl_type ctl;
   logic [31:0] rd_key, rd_val;

   sxt_seq u_seq (.clock, .reset, .req(req_chan), .rsp(rsp_chan), .ctl, .rd_key, .rd_val);
   sxt_store u_store (.clock, .ctl, .rd_key, .rd_val);
endmodule

/* src/sxt_store.sv */
// Key and value memories for all catalog tables, one write and one read port.
// Depends on sxt_pkg.
module sxt_store import sxt_pkg::*; (
   input  logic        clock,
   input  mem_ctl_type ctl,
   output logic [31:0] rd_key,
   output logic [31:0] rd_val
);
   logic [31:0] keys_mem [NumCatalogs*TableDepth];
   logic [31:0] vals_mem [NumCatalogs*TableDepth];

   always_ff @(posedge clock) begin
      if (ctl.we) begin
         keys_mem[ctl.waddr] <= ctl.wkey;
         vals_mem[ctl.waddr] <= ctl.wval;
      end
      rd_key <= keys_mem[ctl.raddr];
      rd_val <= vals_mem[ctl.raddr];
   end
endmodule

/* src/sxt_seq.sv */
// Sequencer: binary search, insert shift, reverse scan over the shared store port.
// Depends on sxt_pkg, the channel interfaces and the macros header.
`include "sorted_cross_index_table_core_macros.svh"
module sxt_seq import sxt_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   sxt_req_if.sink     req,
   sxt_rsp_if.source   rsp,
   output mem_ctl_type ctl,
   input  logic [31:0] rd_key,
   input  logic [31:0] rd_val
);
   state_type        state_ff, state_in;
   req_type          item_ff, item_in;
   logic [CntW-1:0]  counts_ff [NumCatalogs];
   logic [CntW-1:0]  lo_ff, lo_in, hi_ff, hi_in, idx_ff, idx_in, n_cur;
   logic [CntW-1:0]  mid;
   logic             pend_ff, pend_in;
   rsp_type          out_ff, out_in;
   logic [CatW-1:0]  cat;
   logic             bad_cat, go_right;

   assign cat     = item_ff.catalog[CatW-1:0];
   assign bad_cat = ({28'd0, item_ff.catalog} >= 32'(NumCatalogs));
   assign n_cur   = counts_ff[cat];
   assign mid     = lo_ff + ((hi_ff - lo_ff) >> 1);
   assign go_right = (item_ff.mode == MODE_INSERT) ? (rd_key <= item_ff.entry_key)
                                                   : (rd_key < item_ff.entry_key);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req.valid && req.ready) state_in = S_CHECK;
         end
         S_CHECK: begin
            state_in = S_DONE;
            if (!bad_cat) begin
               case (item_ff.mode)
                  MODE_CLEAR:   state_in = S_DONE;
                  MODE_INSERT:  if (n_cur < CntW'(TableDepth)) state_in = S_SEARCH;
                  MODE_LOOKUP:  state_in = S_SEARCH;
                  MODE_REVERSE: state_in = S_SCAN;
                  default:      state_in = S_DONE;
               endcase
            end
         end
         S_SEARCH: begin
            if (lo_ff >= hi_ff) begin
               if (item_ff.mode == MODE_INSERT) state_in = S_SHIFT;
               else if (idx_ff[0] == 1'b1) state_in = S_DONE;
            end
         end
         S_SHIFT:  state_in = S_WRITE;
         S_WRITE:  state_in = (idx_ff != lo_ff && hi_ff == '0) ? S_SHIFT : S_DONE;
         S_SCAN: begin
            if (hi_ff == '0) state_in = S_DONE;
            else if (lo_ff != '0) begin
               if (rd_val == item_ff.entry_value || idx_ff + 1'b1 >= n_cur)
                  state_in = S_DONE;
            end
         end
         S_DONE:   state_in = S_IDLE;
         default:  state_in = S_IDLE;
      endcase
   end

   always_comb begin
      item_in = item_ff;
      lo_in = lo_ff; hi_in = hi_ff; idx_in = idx_ff;
      pend_in = pend_ff; out_in = out_ff;
      ctl = '0;
      ctl.waddr = {cat, idx_ff[PosW-1:0]};
      ctl.wkey = item_ff.entry_key;
      ctl.wval = item_ff.entry_value;
      ctl.raddr = {cat, mid[PosW-1:0]};
      if (rsp.ready) pend_in = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (req.valid && req.ready) item_in = req.payload;
         end
         S_CHECK: begin
            lo_in = '0; hi_in = n_cur; idx_in = '0;
            out_in = '{found: 1'b0, result_number: MissNumber, status: ST_OK};
            if (bad_cat) out_in.status = ST_BAD_CATALOG;
            else if (item_ff.mode == MODE_INSERT && n_cur >= CntW'(TableDepth))
               out_in.status = ST_FULL;
         end
         S_SEARCH: begin
            // read issued at mid; evaluate on the cycle after (idx toggles phase)
            if (lo_ff >= hi_ff) begin
               if (item_ff.mode == MODE_INSERT) begin
                  idx_in = n_cur;
               end else if (idx_ff[0] == 1'b0) begin
                  idx_in = CntW'(1); // read at lo for equality
               end else begin
                  if (lo_ff < n_cur && rd_key == item_ff.entry_key) begin
                     out_in.found = 1'b1; out_in.result_number = rd_val;
                  end
               end
            end else if (idx_ff[0] == 1'b0) begin
               idx_in = CntW'(1);
            end else begin
               idx_in = '0;
               if (go_right) lo_in = mid + 1'b1; else hi_in = mid;
            end
         end
         S_SHIFT: begin
            ctl.raddr = {cat, PosW'(idx_ff - 1'b1)};
            if (idx_ff != lo_ff) hi_in = '0;
         end
         S_WRITE: begin
            ctl.we = 1'b1;
            if (idx_ff != lo_ff && hi_ff == '0) begin
               ctl.wkey = rd_key; ctl.wval = rd_val;
               idx_in = idx_ff - 1'b1; hi_in = CntW'(1);
            end
         end
         S_SCAN: begin
            ctl.raddr = {cat, idx_ff[PosW-1:0]};
            if (hi_ff == '0) begin
               // empty table
            end else if (lo_ff == '0) begin
               lo_in = CntW'(1);
            end else begin
               lo_in = '0;
               if (rd_val == item_ff.entry_value) begin
                  out_in.found = 1'b1; out_in.result_number = rd_key;
               end else if (idx_ff + 1'b1 < n_cur) begin
                  idx_in = idx_ff + 1'b1;
               end
            end
         end
         S_DONE: begin
            pend_in = 1'b1;
         end
         default: begin
         end
      endcase
   end

   assign req.ready = (state_ff == S_IDLE) && !(pend_ff && !rsp.ready);
   assign rsp.valid = pend_ff;
   assign rsp.payload = out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         pend_ff  <= 1'b0;
         for (int c = 0; c < NumCatalogs; c++) counts_ff[c] <= '0;
      end else begin
         state_ff <= state_in;
         pend_ff  <= pend_in;
         if (state_ff == S_CHECK && !bad_cat && item_ff.mode == MODE_CLEAR)
            counts_ff[cat] <= '0;
         if (state_ff == S_WRITE && state_in == S_DONE)
            counts_ff[cat] <= n_cur + 1'b1;
      end
      item_ff <= item_in;
      lo_ff <= lo_in; hi_ff <= hi_in; idx_ff <= idx_in; out_ff <= out_in;
   end

   `SXT_ASSERT_IMP(a_ready_idle, clock, reset, req.ready, state_ff == S_IDLE, "ready outside idle")
   `SXT_ASSERT_NEXT(a_done_pend, clock, reset, state_ff == S_DONE, pend_ff, "result not posted")
   `SXT_ASSERT_IMP(a_we_state, clock, reset, ctl.we, state_ff == S_WRITE, "write outside write")
   `SXT_ASSERT_IMP(a_cnt_lim, clock, reset, state_ff == S_CHECK, n_cur <= CntW'(TableDepth), "count overflow")
endmodule
